/* design/mqmt_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// mqmt_pkg
// Shared types and codes of the multi-queue message table.
// ============================================================================
package mqmt_pkg;

    localparam int FUNC_W = 3;
    localparam int QID_W  = 4;
    localparam int MSG_W  = 32;
    localparam int LEN_W  = 5;
    localparam int STAT_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_CREATE  = 3'd0,
        FN_SEND    = 3'd1,
        FN_RECEIVE = 3'd2,
        FN_DISABLE = 3'd3,
        FN_ENABLE  = 3'd4,
        FN_CLEAR   = 3'd5
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        RC_OK         = 3'd0,
        RC_BAD        = 3'd1,
        RC_FULL       = 3'd2,
        RC_EMPTY      = 3'd3,
        RC_TABLE_FULL = 3'd4,
        RC_BAD_LEN    = 3'd5
    } t_status;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [QID_W-1:0]  queue_id;
        logic [MSG_W-1:0]  message;
        logic [LEN_W-1:0]  queue_length;
    } t_item;

    typedef struct packed {
        logic capture;
        logic meta_rd;
        logic exec_imm;
        logic store_rd;
        logic emit_msg;
    } t_cmd;

    typedef struct packed {
        logic need_msg;
        logic emit_last;
        logic out_free;
    } t_stat;

endpackage

/* design/mqmt_in_if.sv */
`timescale 1ns / 1ps
// ============================================================================
// mqmt_in_if
// Request channel: one operation item per handshake.
// ============================================================================
interface mqmt_in_if;
    logic                         valid;
    logic                         ready;
    logic [mqmt_pkg::FUNC_W-1:0]  func;
    logic [mqmt_pkg::QID_W-1:0]   queue_id;
    logic [mqmt_pkg::MSG_W-1:0]   message;
    logic [mqmt_pkg::LEN_W-1:0]   queue_length;

    modport source (
        output valid, func, queue_id, message, queue_length,
        input  ready
    );

    modport sink (
        input  valid, func, queue_id, message, queue_length,
        output ready
    );
endinterface

/* design/mqmt_out_if.sv */
`timescale 1ns / 1ps
// ============================================================================
// mqmt_out_if
// Result channel: one result item per handshake.
// ============================================================================
interface mqmt_out_if;
    logic                         valid;
    logic                         ready;
    logic [mqmt_pkg::STAT_W-1:0]  status;
    logic [mqmt_pkg::MSG_W-1:0]   message_out;
    logic                         message_valid;
    logic [mqmt_pkg::QID_W-1:0]   created_id;
    logic                         last;

    modport source (
        output valid, status, message_out, message_valid, created_id, last,
        input  ready
    );

    modport sink (
        input  valid, status, message_out, message_valid, created_id, last,
        output ready
    );
endinterface

/* design/mqmt_ctrl.sv */
`timescale 1ns / 1ps
// ============================================================================
// mqmt_ctrl
// Sequencer: steps one operation through metadata read, decision and
// message read-out.
// ============================================================================
module mqmt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  mqmt_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output mqmt_pkg::t_cmd  o_cmd
);
    import mqmt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_META,
        S_DECIDE,
        S_EMIT,
        S_CLR_RD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_META;
                end
            end
            S_META: begin
                o_cmd.meta_rd = 1'b1;
                n_state       = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_stat.need_msg) begin
                    o_cmd.store_rd = 1'b1;
                    n_state        = S_EMIT;
                end else if (i_stat.out_free) begin
                    o_cmd.exec_imm = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_msg = 1'b1;
                    n_state        = i_stat.emit_last ? S_IDLE : S_CLR_RD;
                end
            end
            S_CLR_RD: begin
                o_cmd.store_rd = 1'b1;
                n_state        = S_EMIT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

/* design/mqmt_datapath.sv */
`timescale 1ns / 1ps
// ============================================================================
// mqmt_datapath
// Queue metadata memory, message memory, slot arithmetic, operation
// decode and the result register.
// ============================================================================
module mqmt_datapath #(
    parameter int NUM_QUEUES      = 16,
    parameter int SLOTS_PER_QUEUE = 16,
    parameter int MSG_WIDTH       = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mqmt_pkg::t_item i_item,
    input  mqmt_pkg::t_cmd  i_cmd,
    output mqmt_pkg::t_stat o_stat,
    mqmt_out_if.source      o_out
);
    import mqmt_pkg::*;

    localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int AW    = $clog2(NUM_QUEUES + 1);
    localparam int HW    = (SLOTS_PER_QUEUE > 1) ? $clog2(SLOTS_PER_QUEUE) : 1;
    localparam int CW    = $clog2(SLOTS_PER_QUEUE + 1);
    localparam int SW    = CW + 1;
    localparam int DEPTH = NUM_QUEUES * SLOTS_PER_QUEUE;
    localparam int DW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // per-queue metadata, a queue is in use when its index is below r_alloc_cnt
    logic [CW-1:0]        r_cap_mem  [NUM_QUEUES];
    logic [HW-1:0]        r_head_mem [NUM_QUEUES];
    logic [CW-1:0]        r_fill_mem [NUM_QUEUES];
    logic                 r_dis_mem  [NUM_QUEUES];
    logic [MSG_WIDTH-1:0] r_store_mem [DEPTH];

    t_item                r_item;
    logic                 r_qid_ok;
    logic [CW-1:0]        r_cnt;
    logic [AW-1:0]        r_alloc_cnt;
    logic [CW-1:0]        r_cap;
    logic [HW-1:0]        r_head;
    logic [CW-1:0]        r_fill;
    logic                 r_dis;
    logic [MSG_WIDTH-1:0] r_rd_data;

    logic                 r_out_valid;
    logic [STAT_W-1:0]    r_status;
    logic [MSG_W-1:0]     r_msg_out;
    logic                 r_msg_valid;
    logic [QID_W-1:0]     r_created;
    logic                 r_last;

    logic [QW-1:0]        w_qidx;
    logic [CW-1:0]        w_off;
    logic [SW-1:0]        w_sum;
    logic [HW-1:0]        w_pos;
    logic [DW-1:0]        w_slot;
    logic [CW-1:0]        w_hp1;
    logic                 w_emit_last;
    logic                 w_out_free;

    logic                 in_use;
    logic                 is_alloc;
    logic                 is_dis;
    logic                 bad_len;
    logic                 tbl_full;

    t_status              d_status;
    logic                 d_need_msg;
    logic [QID_W-1:0]     d_created;
    logic                 d_meta_we;
    logic [QW-1:0]        d_meta_addr;
    logic [CW-1:0]        d_cap;
    logic [HW-1:0]        d_head;
    logic [CW-1:0]        d_fill;
    logic                 d_dis;
    logic                 d_store_we;
    logic                 d_alloc_inc;

    logic                 w_meta_we;
    logic [QW-1:0]        w_meta_addr;
    logic [CW-1:0]        w_cap;
    logic [HW-1:0]        w_head;
    logic [CW-1:0]        w_fill;
    logic                 w_dis;

    assign w_qidx = QW'(r_item.queue_id);

    // circular slot: head plus offset, wrapped once by capacity
    always_comb begin
        w_off = (r_item.func == FN_SEND) ? r_fill : r_cnt;
        w_sum = SW'(r_head) + SW'(w_off);
        if (w_sum >= SW'(r_cap)) begin
            w_sum = w_sum - SW'(r_cap);
        end
        w_pos  = HW'(w_sum);
        w_slot = DW'(w_qidx) * DW'(SLOTS_PER_QUEUE) + DW'(w_pos);
        w_hp1  = CW'(r_head) + CW'(1);
    end

    assign w_emit_last = (r_item.func == FN_RECEIVE) || ((r_cnt + CW'(1)) == r_fill);
    assign w_out_free  = !r_out_valid || o_out.ready;

    always_comb begin
        in_use   = r_qid_ok && (AW'(w_qidx) < r_alloc_cnt);
        is_alloc = in_use && !r_dis;
        is_dis   = in_use && r_dis;
        bad_len  = (r_item.queue_length == '0)
                || (32'(r_item.queue_length) > 32'(SLOTS_PER_QUEUE));
        tbl_full = (32'(r_alloc_cnt) == 32'(NUM_QUEUES));

        d_status    = RC_BAD;
        d_need_msg  = 1'b0;
        d_created   = '0;
        d_meta_we   = 1'b0;
        d_meta_addr = w_qidx;
        d_cap       = r_cap;
        d_head      = r_head;
        d_fill      = r_fill;
        d_dis       = r_dis;
        d_store_we  = 1'b0;
        d_alloc_inc = 1'b0;

        case (r_item.func)
            FN_CREATE: begin
                if (bad_len) begin
                    d_status = RC_BAD_LEN;
                end else if (tbl_full) begin
                    d_status = RC_TABLE_FULL;
                end else begin
                    d_status    = RC_OK;
                    d_created   = QID_W'(r_alloc_cnt);
                    d_meta_we   = 1'b1;
                    d_meta_addr = QW'(r_alloc_cnt);
                    d_cap       = CW'(r_item.queue_length);
                    d_head      = '0;
                    d_fill      = '0;
                    d_dis       = 1'b0;
                    d_alloc_inc = 1'b1;
                end
            end
            FN_SEND: begin
                if (!is_alloc) begin
                    d_status = RC_BAD;
                end else if (r_fill >= r_cap) begin
                    d_status = RC_FULL;
                end else begin
                    d_status   = RC_OK;
                    d_store_we = 1'b1;
                    d_meta_we  = 1'b1;
                    d_fill     = r_fill + CW'(1);
                end
            end
            FN_RECEIVE: begin
                if (!is_alloc) begin
                    d_status = RC_BAD;
                end else if (r_fill == '0) begin
                    d_status = RC_EMPTY;
                end else begin
                    d_status   = RC_OK;
                    d_need_msg = 1'b1;
                end
            end
            FN_DISABLE: begin
                if (is_alloc) begin
                    d_status  = RC_OK;
                    d_meta_we = 1'b1;
                    d_dis     = 1'b1;
                end
            end
            FN_ENABLE: begin
                if (is_dis) begin
                    d_status  = RC_OK;
                    d_meta_we = 1'b1;
                    d_dis     = 1'b0;
                end
            end
            FN_CLEAR: begin
                if (is_dis) begin
                    d_status   = RC_OK;
                    d_need_msg = (r_fill != '0);
                end
            end
            default: begin
                d_status = RC_BAD;
            end
        endcase
    end

    // metadata write: immediate ops, or the last message of a receive or clear
    always_comb begin
        w_meta_we   = 1'b0;
        w_meta_addr = d_meta_addr;
        w_cap       = d_cap;
        w_head      = d_head;
        w_fill      = d_fill;
        w_dis       = d_dis;
        if (i_cmd.exec_imm) begin
            w_meta_we = d_meta_we;
        end else if (i_cmd.emit_msg && w_emit_last) begin
            w_meta_we   = 1'b1;
            w_meta_addr = w_qidx;
            w_cap       = r_cap;
            w_dis       = r_dis;
            if (r_item.func == FN_RECEIVE) begin
                w_head = (w_hp1 == r_cap) ? '0 : HW'(w_hp1);
                w_fill = r_fill - CW'(1);
            end else begin
                w_head = r_head;
                w_fill = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_meta_we) begin
            r_cap_mem[w_meta_addr]  <= w_cap;
            r_head_mem[w_meta_addr] <= w_head;
            r_fill_mem[w_meta_addr] <= w_fill;
            r_dis_mem[w_meta_addr]  <= w_dis;
        end
        if (i_cmd.meta_rd) begin
            r_cap  <= r_cap_mem[w_qidx];
            r_head <= r_head_mem[w_qidx];
            r_fill <= r_fill_mem[w_qidx];
            r_dis  <= r_dis_mem[w_qidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec_imm && d_store_we) begin
            r_store_mem[w_slot] <= MSG_WIDTH'(r_item.message);
        end
        if (i_cmd.store_rd) begin
            r_rd_data <= r_store_mem[w_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec_imm && d_alloc_inc) begin
                r_alloc_cnt <= r_alloc_cnt + AW'(1);
            end
            if (i_cmd.exec_imm || i_cmd.emit_msg) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item   <= i_item;
            r_qid_ok <= (32'(i_item.queue_id) < 32'(NUM_QUEUES));
            r_cnt    <= '0;
        end else if (i_cmd.emit_msg) begin
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.exec_imm) begin
            r_status    <= d_status;
            r_msg_out   <= '0;
            r_msg_valid <= 1'b0;
            r_created   <= d_created;
            r_last      <= 1'b1;
        end else if (i_cmd.emit_msg) begin
            r_status    <= RC_OK;
            r_msg_out   <= MSG_W'(r_rd_data);
            r_msg_valid <= 1'b1;
            r_created   <= '0;
            r_last      <= w_emit_last;
        end
    end

    assign o_stat.need_msg  = d_need_msg;
    assign o_stat.emit_last = w_emit_last;
    assign o_stat.out_free  = w_out_free;

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.message_out   = r_msg_out;
    assign o_out.message_valid = r_msg_valid;
    assign o_out.created_id    = r_created;
    assign o_out.last          = r_last;

`ifndef SYNTH
    a_alloc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_alloc_cnt) <= 32'(NUM_QUEUES))
        else $error("allocation count beyond table size");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec_imm || i_cmd.emit_msg) |-> (!r_out_valid || o_out.ready))
        else $error("result register overwritten while occupied");

    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_msg |-> (r_cnt < r_fill))
        else $error("message read past queue fill");

    a_last_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_msg && w_emit_last) |=>
            (o_out.valid && o_out.last && o_out.message_valid))
        else $error("final message item not marked last");
`endif

endmodule

/* design/multi_queue_message_table.sv */
`timescale 1ns / 1ps
// ============================================================================
// multi_queue_message_table
// Table of circular message queues with create, send, receive, disable,
// enable and clear operations.
// ============================================================================
// One operation item is taken at a time. Create, send, disable, enable and
// rejected operations step through accept, metadata memory read, decide and
// update before the result is loaded. A successful receive adds one
// registered read of the message memory. A clear of a queue holding
// messages does one message memory read and one result load per message.
// Both memories are single-port with a registered read; a stalled result
// channel holds the operation until the result register is free. The result
// register lets a new item be accepted while the previous result waits.
// After reset every queue is free with no clearing pass, since free queues
// are tracked by an allocation count.
// ============================================================================
module multi_queue_message_table #(
    parameter int NUM_QUEUES      = 16,
    parameter int SLOTS_PER_QUEUE = 16,
    parameter int MSG_WIDTH       = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mqmt_in_if.sink    i_in,
    mqmt_out_if.source o_out
);
    import mqmt_pkg::*;

    t_item w_item;
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    assign w_item.func         = i_in.func;
    assign w_item.queue_id     = i_in.queue_id;
    assign w_item.message      = i_in.message;
    assign w_item.queue_length = i_in.queue_length;
    assign i_in.ready          = w_in_ready;

    mqmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    mqmt_datapath #(
        .NUM_QUEUES      (NUM_QUEUES),
        .SLOTS_PER_QUEUE (SLOTS_PER_QUEUE),
        .MSG_WIDTH       (MSG_WIDTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_item),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_out   (o_out)
    );

endmodule

/* tb/tb_multi_queue_message_table.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_multi_queue_message_table
// Self-checking bench for the multi-queue message table.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the queue table. Every accepted request
// updates that copy and queues the results it should cause. Every accepted
// result is compared field by field with the oldest of them. A directed run
// covers each operation and each error path but a full table. A random run
// follows it in four idling phases and mixes single operations with fill, disable,
// clear and enable sequences, so that full queues are drained by long clears.
// ============================================================================
module tb_multi_queue_message_table;
    import mqmt_pkg::*;

    localparam int NQ    = 16;
    localparam int SLOTS = 16;

    localparam logic [FUNC_W-1:0] FN_RSVD_A = 3'd6;
    localparam logic [FUNC_W-1:0] FN_RSVD_B = 3'd7;

    typedef enum logic [1:0] {
        QS_FREE     = 2'd0,
        QS_ALLOC    = 2'd1,
        QS_DISABLED = 2'd2
    } t_qstate;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [MSG_W-1:0]  message_out;
        logic              message_valid;
        logic [QID_W-1:0]  created_id;
        logic              last;
    } t_result;

    class msg_table_scoreboard;
        t_qstate          qstate   [NQ];
        logic [LEN_W-1:0] capacity [NQ];
        logic [QID_W-1:0] head     [NQ];
        logic [LEN_W-1:0] fill     [NQ];
        logic [MSG_W-1:0] slots    [NQ*SLOTS];
        t_result          pending_results[$];
        int errors;
        int n_requests;
        int n_results;
        int n_created;
        int n_table_full;
        int longest_clear;

        function new();
            for (int i = 0; i < NQ; i++) begin
                qstate[i]   = QS_FREE;
                capacity[i] = '0;
                head[i]     = '0;
                fill[i]     = '0;
            end
            errors        = 0;
            n_requests    = 0;
            n_results     = 0;
            n_created     = 0;
            n_table_full  = 0;
            longest_clear = 0;
        endfunction

        function int slot_index(int q, int offset);
            return q * SLOTS + (int'(head[q]) + offset) % int'(capacity[q]);
        endfunction

        function void push(logic [STAT_W-1:0] st, logic [MSG_W-1:0] m, logic mv,
                           logic [QID_W-1:0] cid, logic lst);
            t_result r;
            r.status        = st;
            r.message_out   = m;
            r.message_valid = mv;
            r.created_id    = cid;
            r.last          = lst;
            pending_results.push_back(r);
        endfunction

        function void note_request(t_item it);
            int q;
            int found;
            int n;
            q = int'(it.queue_id);
            n_requests++;
            case (it.func)
                FN_CREATE: begin
                    if (it.queue_length == 0 || it.queue_length > SLOTS) begin
                        push(RC_BAD_LEN, '0, 1'b0, '0, 1'b1);
                    end else begin
                        found = -1;
                        for (int i = 0; i < NQ; i++) begin
                            if (found < 0 && qstate[i] == QS_FREE) found = i;
                        end
                        if (found < 0) begin
                            n_table_full++;
                            push(RC_TABLE_FULL, '0, 1'b0, '0, 1'b1);
                        end else begin
                            qstate[found]   = QS_ALLOC;
                            capacity[found] = it.queue_length;
                            head[found]     = '0;
                            fill[found]     = '0;
                            n_created++;
                            push(RC_OK, '0, 1'b0, QID_W'(found), 1'b1);
                        end
                    end
                end
                FN_SEND: begin
                    if (qstate[q] != QS_ALLOC) begin
                        push(RC_BAD, '0, 1'b0, '0, 1'b1);
                    end else if (fill[q] >= capacity[q]) begin
                        push(RC_FULL, '0, 1'b0, '0, 1'b1);
                    end else begin
                        slots[slot_index(q, int'(fill[q]))] = it.message;
                        fill[q]++;
                        push(RC_OK, '0, 1'b0, '0, 1'b1);
                    end
                end
                FN_RECEIVE: begin
                    if (qstate[q] != QS_ALLOC) begin
                        push(RC_BAD, '0, 1'b0, '0, 1'b1);
                    end else if (fill[q] == 0) begin
                        push(RC_EMPTY, '0, 1'b0, '0, 1'b1);
                    end else begin
                        push(RC_OK, slots[slot_index(q, 0)], 1'b1, '0, 1'b1);
                        head[q] = QID_W'((int'(head[q]) + 1) % int'(capacity[q]));
                        fill[q]--;
                    end
                end
                FN_DISABLE: begin
                    if (qstate[q] != QS_ALLOC) begin
                        push(RC_BAD, '0, 1'b0, '0, 1'b1);
                    end else begin
                        qstate[q] = QS_DISABLED;
                        push(RC_OK, '0, 1'b0, '0, 1'b1);
                    end
                end
                FN_ENABLE: begin
                    if (qstate[q] != QS_DISABLED) begin
                        push(RC_BAD, '0, 1'b0, '0, 1'b1);
                    end else begin
                        qstate[q] = QS_ALLOC;
                        push(RC_OK, '0, 1'b0, '0, 1'b1);
                    end
                end
                FN_CLEAR: begin
                    if (qstate[q] != QS_DISABLED) begin
                        push(RC_BAD, '0, 1'b0, '0, 1'b1);
                    end else begin
                        n = int'(fill[q]);
                        if (n == 0) begin
                            push(RC_OK, '0, 1'b0, '0, 1'b1);
                        end else begin
                            for (int i = 0; i < n; i++) begin
                                push(RC_OK, slots[slot_index(q, i)], 1'b1, '0, i == n - 1);
                            end
                            if (n > longest_clear) longest_clear = n;
                            fill[q] = '0;
                        end
                    end
                end
                default: begin
                    push(RC_BAD, '0, 1'b0, '0, 1'b1);
                end
            endcase
        endfunction

        function void compare_field(string name, logic [MSG_W-1:0] want,
                                    logic [MSG_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                         want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            n_results++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h", $time,
                         got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                compare_field("status", MSG_W'(want.status), MSG_W'(got.status));
                compare_field("message_out", want.message_out, got.message_out);
                compare_field("message_valid", MSG_W'(want.message_valid),
                              MSG_W'(got.message_valid));
                compare_field("created_id", MSG_W'(want.created_id),
                              MSG_W'(got.created_id));
                compare_field("last", MSG_W'(want.last), MSG_W'(got.last));
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    msg_table_scoreboard table_sb;

    mqmt_in_if  req_ch ();
    mqmt_out_if rsp_ch ();

    multi_queue_message_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #(5_000_000);
        $display("simulation failed");
        $finish;
    end

    // result side: ready changes at the falling edge, items taken at the rising edge
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_ch.ready = i_rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.status        = rsp_ch.status;
            got.message_out   = rsp_ch.message_out;
            got.message_valid = rsp_ch.message_valid;
            got.created_id    = rsp_ch.created_id;
            got.last          = rsp_ch.last;
            table_sb.check_result(got);
        end
    end

    task automatic drive_request(input logic [FUNC_W-1:0] fn, input logic [QID_W-1:0] qid,
                                 input logic [MSG_W-1:0] msg, input logic [LEN_W-1:0] len);
        t_item it;
        it.func         = fn;
        it.queue_id     = qid;
        it.message      = msg;
        it.queue_length = len;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid        = 1'b1;
        req_ch.func         = fn;
        req_ch.queue_id     = qid;
        req_ch.message      = msg;
        req_ch.queue_length = len;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        table_sb.note_request(it);
        @(negedge i_clk);
    endtask

    task automatic op(input logic [FUNC_W-1:0] fn, input int q);
        drive_request(fn, QID_W'(q), $urandom, LEN_W'($urandom_range(0, 31)));
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return LEN_W'($urandom_range(SLOTS + 1, 31));
        if (r < 55) return LEN_W'($urandom_range(1, 4));
        if (r < 80) return LEN_W'($urandom_range(5, SLOTS - 1));
        return LEN_W'(SLOTS);
    endfunction

    function automatic int pick_queue();
        int used[$];
        for (int i = 0; i < NQ; i++) begin
            if (table_sb.qstate[i] != QS_FREE) used.push_back(i);
        end
        if (used.size() == 0 || $urandom_range(0, 99) < 15) return $urandom_range(0, NQ - 1);
        return used[$urandom_range(0, used.size() - 1)];
    endfunction

    task automatic run_directed();
        drive_request(FN_CREATE, 4'd0, '0, 5'd0);
        drive_request(FN_CREATE, 4'd0, '0, 5'd17);
        drive_request(FN_CREATE, 4'd0, '0, 5'd31);
        drive_request(FN_CREATE, 4'd0, '0, 5'd1);
        drive_request(FN_CREATE, 4'd0, '0, 5'd16);
        drive_request(FN_SEND, 4'd0, 32'h0000_0000, '0);
        drive_request(FN_SEND, 4'd0, 32'hffff_ffff, '0);
        drive_request(FN_RECEIVE, 4'd0, '0, '0);
        drive_request(FN_RECEIVE, 4'd0, '0, '0);
        drive_request(FN_SEND, 4'd15, 32'h1234_5678, '0);
        drive_request(FN_RECEIVE, 4'd15, '0, '0);
        drive_request(FN_DISABLE, 4'd15, '0, '0);
        drive_request(FN_ENABLE, 4'd0, '0, '0);
        drive_request(FN_CLEAR, 4'd0, '0, '0);
        drive_request(FN_RSVD_A, 4'd0, '0, 5'd4);
        drive_request(FN_RSVD_B, 4'd15, 32'hffff_ffff, 5'd31);
        drive_request(FN_SEND, 4'd1, 32'hffff_ffff, '0);
        drive_request(FN_SEND, 4'd1, 32'ha5a5_5a5a, '0);
        drive_request(FN_DISABLE, 4'd1, '0, '0);
        drive_request(FN_SEND, 4'd1, 32'h0bad_0bad, '0);
        drive_request(FN_DISABLE, 4'd1, '0, '0);
        drive_request(FN_CLEAR, 4'd1, '0, '0);
        drive_request(FN_CLEAR, 4'd1, '0, '0);
        drive_request(FN_ENABLE, 4'd1, '0, '0);
        drive_request(FN_RECEIVE, 4'd1, '0, '0);
    endtask

    task automatic run_random(input int total);
        int issued;
        int phase;
        int r;
        int q;
        int n;
        issued = 0;
        while (issued < total) begin
            phase = issued * 4 / total;
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            r = $urandom_range(0, 99);
            q = pick_queue();
            if (r < 6) begin
                // fill the queue to the brim, then drain it with one clear
                n = 0;
                if (table_sb.qstate[q] == QS_ALLOC) begin
                    n = int'(table_sb.capacity[q]) - int'(table_sb.fill[q]);
                end
                repeat (n) op(FN_SEND, q);
                op(FN_DISABLE, q);
                op(FN_CLEAR, q);
                op(FN_ENABLE, q);
                issued += n + 3;
            end else if (r < 14) begin
                op(FN_DISABLE, q);
                op(FN_CLEAR, q);
                op(FN_ENABLE, q);
                issued += 3;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    drive_request(FN_CREATE, QID_W'($urandom), $urandom, pick_length());
                end else if (r < 45) begin
                    op(FN_SEND, q);
                end else if (r < 70) begin
                    op(FN_RECEIVE, q);
                end else if (r < 78) begin
                    op(FN_DISABLE, q);
                end else if (r < 86) begin
                    op(FN_ENABLE, q);
                end else if (r < 94) begin
                    op(FN_CLEAR, q);
                end else if (r < 97) begin
                    op(FN_RSVD_A, q);
                end else begin
                    op(FN_RSVD_B, q);
                end
                issued++;
            end
        end
    endtask

    initial begin
        int guard;
        table_sb            = new();
        req_ch.valid        = 1'b0;
        req_ch.func         = '0;
        req_ch.queue_id     = '0;
        req_ch.message      = '0;
        req_ch.queue_length = '0;
        i_rst_n             = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        run_directed();
        run_random(360);
        req_ch.valid = 1'b0;

        guard = 0;
        while (table_sb.pending_results.size() != 0 && guard < 200_000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);
        if (table_sb.pending_results.size() != 0) begin
            $display("%0t: results outstanding, expected 0, actual %0d", $time,
                     table_sb.pending_results.size());
            table_sb.errors++;
        end

        $display("covered %0d requests and %0d results across four idling phases",
                 table_sb.n_requests, table_sb.n_results);
        $display("queues created %0d, table-full rejections %0d, longest clear %0d items",
                 table_sb.n_created, table_sb.n_table_full, table_sb.longest_clear);
        if (table_sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* sim.f */
design/mqmt_pkg.sv
design/mqmt_in_if.sv
design/mqmt_out_if.sv
design/mqmt_ctrl.sv
design/mqmt_datapath.sv
design/multi_queue_message_table.sv
tb/tb_multi_queue_message_table.sv
